[design/obm_pkg.sv]
`timescale 1ns / 1ps
package obm_pkg;
  localparam int unsigned PRICE_W = 32;
  localparam int unsigned QTY_W   = 32;
  localparam int unsigned OID_W   = 32;
  localparam int unsigned CID_W   = 16;
  localparam int unsigned SYM_W   = 8;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned ENTRY_W = PRICE_W + QTY_W + OID_W + CID_W;

  typedef enum logic [STAT_W-1:0] {
    ST_QUEUED   = 2'd0,
    ST_MATCHED  = 2'd1,
    ST_REJECTED = 2'd2
  } status_t;

  typedef struct packed {
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   qty;
    logic [OID_W-1:0]   oid;
    logic [CID_W-1:0]   cid;
  } entry_t;

  // compare unit request
  typedef struct packed {
    logic               buy;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   qty;
  } cmp_req_t;
endpackage

[design/order_book_match_top.sv]
`timescale 1ns / 1ps
// channel | ports                                  | direction
// in      | in_valid/in_stall, order fields       | request into block
// out     | out_valid/out_stall, result fields     | result from block
// A miss scans every resting entry of the opposite queue; a hit removes the matched
// entry and shifts the later entries of that queue down.
// The slot read is registered: each entry is addressed, then compared.
// After reset a clearing pass zeroes the 2*SYMBOLS queue counts.
// The result register holds until taken; no new order is taken meanwhile.
module order_book_match_top #(
  parameter int unsigned SYMBOLS     = 256,
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_kind,
  input  logic [obm_pkg::SYM_W-1:0]     in_symbol_index,
  input  logic [obm_pkg::PRICE_W-1:0]   in_price,
  input  logic [obm_pkg::QTY_W-1:0]     in_quantity,
  input  logic [obm_pkg::OID_W-1:0]     in_order_id,
  input  logic [obm_pkg::CID_W-1:0]     in_client_id,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [obm_pkg::STAT_W-1:0]    out_status,
  output logic [obm_pkg::OID_W-1:0]     out_matched_order_id,
  output logic [obm_pkg::CID_W-1:0]     out_matched_client_id,
  output logic [obm_pkg::PRICE_W-1:0]   out_exec_price,
  output logic [obm_pkg::QTY_W-1:0]     out_exec_quantity
);
  localparam int unsigned SW  = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
  localparam int unsigned QW  = SW + 1;
  localparam int unsigned NQ  = 2 * SYMBOLS;
  localparam int unsigned DW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned AW  = QW + DW;
  localparam int unsigned SYM_RECIP = 65536 / SYMBOLS;

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_CNT   = 9'b000000100,
    S_RD    = 9'b000001000,
    S_CMP   = 9'b000010000,
    S_SRD   = 9'b000100000,
    S_SWR   = 9'b001000000,
    S_OWN   = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  // queue counts live in a memory; clear pass after reset
  logic [CW-1:0] cnt_mem [NQ];
  logic          cnt_we;
  logic [QW-1:0] cnt_waddr, cnt_raddr;
  logic [CW-1:0] cnt_wdata, cnt_rdata;
  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    cnt_rdata <= cnt_mem[cnt_raddr];
  end

  logic [QW-1:0]   clr_r;
  logic [QW-1:0]   opp_r, own_r;
  obm_pkg::cmp_req_t req_r;
  logic [obm_pkg::OID_W-1:0] oid_r;
  logic [obm_pkg::CID_W-1:0] cid_r;
  logic [CW-1:0]   n_r;
  logic [CW-1:0]   k_r;
  logic            phase_r;   // 0: scan opposite, 1: count of own side read
  obm_pkg::entry_t hit_ent_r;

  logic            mem_we;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  obm_pkg::entry_t mem_wdata, mem_rdata;
  logic            hit;

  obm_mem #(.AW(AW)) u_mem (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(mem_rdata)
  );
  obm_cmp u_cmp (.req(req_r), .ent(mem_rdata), .hit(hit));

  // index modulo SYMBOLS by reciprocal; one correction step covers an 8-bit index
  logic [SW-1:0] sym_in;
  logic [31:0]   sym_q, sym_r;
  always_comb begin
    sym_q = (32'(in_symbol_index) * 32'(SYM_RECIP)) >> 16;
    sym_r = 32'(in_symbol_index) - sym_q * 32'(SYMBOLS);
    if (sym_r >= 32'(SYMBOLS)) begin
      sym_r = sym_r - 32'(SYMBOLS);
    end
    if (SYMBOLS == 2**SW) begin
      sym_in = SW'(in_symbol_index);
    end else begin
      sym_in = SW'(sym_r);
    end
  end

  logic [DW-1:0] k_idx, k1_idx;
  assign k_idx  = k_r[DW-1:0];
  assign k1_idx = DW'(k_r + CW'(1));

  logic in_acc, out_acc;
  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    state_nxt = state_r;
    cnt_we    = 1'b0;
    cnt_waddr = opp_r;
    cnt_wdata = '0;
    cnt_raddr = opp_r;
    mem_we    = 1'b0;
    mem_waddr = {opp_r, k_idx};
    mem_wdata = mem_rdata;
    mem_raddr = {opp_r, k_idx};
    unique case (state_r)
      S_CLEAR: begin
        cnt_we    = 1'b1;
        cnt_waddr = clr_r;
        if (clr_r == QW'(NQ - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        cnt_raddr = {sym_in, ~in_kind};
        if (in_acc) begin
          state_nxt = S_CNT;
        end
      end
      S_CNT: begin
        if (phase_r) begin
          cnt_raddr = own_r;
          state_nxt = S_OWN;
        end else if (cnt_rdata == '0) begin
          cnt_raddr = own_r;
          state_nxt = S_CNT;
        end else begin
          state_nxt = S_RD;
        end
      end
      S_RD: state_nxt = S_CMP;
      S_CMP: begin
        if (hit) begin
          state_nxt = S_SRD;
        end else if (k_r + CW'(1) >= n_r) begin
          cnt_raddr = own_r;
          state_nxt = S_CNT;
        end else begin
          state_nxt = S_RD;
        end
      end
      S_SRD: begin
        mem_raddr = {opp_r, k1_idx};
        if (k_r + CW'(1) >= n_r) begin
          cnt_we    = 1'b1;
          cnt_wdata = n_r - CW'(1);
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_SWR;
        end
      end
      S_SWR: begin
        mem_we    = 1'b1;
        state_nxt = S_SRD;
      end
      S_OWN: begin
        if (cnt_rdata < CW'(QUEUE_DEPTH)) begin
          mem_we    = 1'b1;
          mem_waddr = {own_r, cnt_rdata[DW-1:0]};
          mem_wdata = '{price: req_r.price, qty: req_r.qty, oid: oid_r, cid: cid_r};
          cnt_we    = 1'b1;
          cnt_waddr = own_r;
          cnt_wdata = cnt_rdata + CW'(1);
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_acc) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_r <= clr_r + QW'(1);
      end
    end
  end

  logic [obm_pkg::STAT_W-1:0] stat_r;
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        opp_r   <= {sym_in, ~in_kind};
        own_r   <= {sym_in, in_kind};
        req_r   <= '{buy: in_kind, price: in_price, qty: in_quantity};
        oid_r   <= in_order_id;
        cid_r   <= in_client_id;
        phase_r <= 1'b0;
        k_r     <= '0;
      end
      S_CNT: begin
        if (!phase_r) begin
          n_r <= (cnt_rdata > CW'(QUEUE_DEPTH)) ? CW'(QUEUE_DEPTH) : cnt_rdata;
          if (cnt_rdata == '0) begin
            phase_r <= 1'b1;
          end
        end
      end
      S_CMP: begin
        if (hit) begin
          hit_ent_r <= mem_rdata;
        end else if (k_r + CW'(1) >= n_r) begin
          phase_r <= 1'b1;
        end else begin
          k_r <= k_r + CW'(1);
        end
      end
      S_SWR: k_r <= k_r + CW'(1);
      default: ;
    endcase
    if (state_r == S_SRD && k_r + CW'(1) >= n_r) begin
      stat_r <= obm_pkg::ST_MATCHED;
    end else if (state_r == S_OWN) begin
      stat_r <= (cnt_rdata < CW'(QUEUE_DEPTH)) ? obm_pkg::ST_QUEUED : obm_pkg::ST_REJECTED;
    end
  end

  logic matched;
  assign matched = (stat_r == obm_pkg::ST_MATCHED);
  assign out_status            = stat_r;
  assign out_matched_order_id  = matched ? hit_ent_r.oid : '0;
  assign out_matched_client_id = matched ? hit_ent_r.cid : '0;
  assign out_exec_price        = matched ? req_r.price : '0;
  assign out_exec_quantity     = matched ? req_r.qty : '0;

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_acc) else $error("order taken while busy");
  a_out_after: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |=> (state_r == S_IDLE)) else $error("no return to idle");
  a_status_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == obm_pkg::ST_QUEUED || out_status == obm_pkg::ST_MATCHED
                   || out_status == obm_pkg::ST_REJECTED)) else $error("bad status");
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP) |-> (k_r < n_r)) else $error("scan past count");
endmodule

[design/obm_cmp.sv]
`timescale 1ns / 1ps
// shared compare unit: one resting entry per cycle against the aggressor
module obm_cmp (
  input  obm_pkg::cmp_req_t req,
  input  obm_pkg::entry_t   ent,
  output logic              hit
);
  logic price_ok;
  always_comb begin
    if (req.buy) begin
      price_ok = req.price >= ent.price;
    end else begin
      price_ok = req.price <= ent.price;
    end
    hit = price_ok && (ent.qty == req.qty);
  end
endmodule

[design/obm_mem.sv]
`timescale 1ns / 1ps
// slot store: one write, one registered read a cycle
module obm_mem #(
  parameter int unsigned AW = 13
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  obm_pkg::entry_t   wdata,
  input  logic [AW-1:0]     raddr,
  output obm_pkg::entry_t   rdata
);
  obm_pkg::entry_t mem [2**AW];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
